// ===== hdl/sms_pkg.sv =====
// Shared types and codes for the two-stack memory block.
`default_nettype none
package sms_pkg;

    // Operation codes carried by an input word.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== hdl/sms_if.sv =====
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface sms_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  operation;
    logic               stack_select;
    logic signed [31:0] push_value;

    modport source (output valid, operation, stack_select, push_value, input ready);
    modport sink   (input valid, operation, stack_select, push_value, output ready);
endinterface

interface sms_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] read_value;
    logic               lower_empty;
    logic               upper_empty;

    modport source (output valid, status, read_value, lower_empty, upper_empty,
                    input ready);
    modport sink   (input valid, status, read_value, lower_empty, upper_empty,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/shared_memory_dual_stack.sv =====
// Top level of two LIFO stacks sharing one entry memory.
// An accepted word is registered, executed in the execute state and offered in the
// respond state; no word is taken meanwhile, and the result must be taken before
// the next request word is accepted, and the memory is used once per word.
// Reset: synchronous, active low; both stacks become empty, memory is not cleared.
`default_nettype none
module shared_memory_dual_stack
    import sms_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sms_in_if.sink    i_in,
    sms_out_if.source o_out
);

    // Commands travel from the controller to the datapath as one struct.
    t_dp_cmd cmd;

    // The controller sequences idle, execute and respond phases.
    sms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the memory, the two counts and the result word.
    // The lower stack fills from entry zero up, the upper one from the top down.
    sms_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_in.operation),
        .i_stack_select (i_in.stack_select),
        .i_push_value   (i_in.push_value),
        .o_status       (o_out.status),
        .o_read_value   (o_out.read_value),
        .o_lower_empty  (o_out.lower_empty),
        .o_upper_empty  (o_out.upper_empty)
    );

endmodule
`default_nettype wire

// ===== hdl/sms_ctrl.sv =====
// Controller state machine: accept a word, execute it, hold the result.
`default_nettype none
module sms_ctrl
    import sms_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule
`default_nettype wire

// ===== hdl/sms_dp.sv =====
// Datapath: entry memory, both stack counts and the result registers.
`default_nettype none
module sms_dp
    import sms_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic        [1:0]  i_operation,
    input  wire logic               i_stack_select,
    input  wire logic signed [31:0] i_push_value,
    output logic             [1:0]  o_status,
    output logic signed      [31:0] o_read_value,
    output logic                    o_lower_empty,
    output logic                    o_upper_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_mem_q;

    logic [1:0]    r_op;
    logic          r_sel;
    logic [31:0]   r_val;
    logic [CW-1:0] r_lower_cnt, n_lower_cnt;
    logic [CW-1:0] r_upper_cnt, n_upper_cnt;
    logic [1:0]    r_status, n_status;
    logic          r_use_mem, n_use_mem;

    logic [CW:0]   total;
    logic          full;
    logic          sel_empty;
    logic          mem_we;
    logic [AW-1:0] addr;

    assign total     = {1'b0, r_lower_cnt} + {1'b0, r_upper_cnt};
    assign full      = (total >= {1'b0, DEPTH_C});
    assign sel_empty = r_sel ? (r_upper_cnt == '0) : (r_lower_cnt == '0);

    always_comb begin
        n_lower_cnt = r_lower_cnt;
        n_upper_cnt = r_upper_cnt;
        n_status    = ST_DONE;
        n_use_mem   = 1'b0;
        mem_we      = 1'b0;
        addr        = '0;
        case (r_op) inside
            OP_PUSH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (!r_sel) begin
                    mem_we      = 1'b1;
                    addr        = r_lower_cnt[AW-1:0];
                    n_lower_cnt = r_lower_cnt + 1'b1;
                end else begin
                    mem_we      = 1'b1;
                    addr        = AW'(DEPTH_C - r_upper_cnt - 1'b1);
                    n_upper_cnt = r_upper_cnt + 1'b1;
                end
            end
            OP_POP, OP_PEEK: begin
                if (sel_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_mem = 1'b1;
                    if (r_sel) begin
                        addr = AW'(DEPTH_C - r_upper_cnt);
                        if (r_op == OP_POP) n_upper_cnt = r_upper_cnt - 1'b1;
                    end else begin
                        addr = AW'(r_lower_cnt - 1'b1);
                        if (r_op == OP_POP) n_lower_cnt = r_lower_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Memory: one registered read per executed word, plus a write for a push.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[addr] <= r_val;
        end
        if (i_cmd.exec) begin
            r_mem_q <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_cnt <= '0;
            r_upper_cnt <= '0;
        end else if (i_cmd.exec) begin
            r_lower_cnt <= n_lower_cnt;
            r_upper_cnt <= n_upper_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_sel <= i_stack_select;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_use_mem <= n_use_mem;
        end
    end

    assign o_status      = r_status;
    assign o_read_value  = r_use_mem ? r_mem_q : '0;
    assign o_lower_empty = (r_lower_cnt == '0);
    assign o_upper_empty = (r_upper_cnt == '0);

endmodule
`default_nettype wire

// ===== hdl/sms_checker.sv =====
// Port-level checks for the two-stack block, bound to the top level.
`default_nettype none
module sms_checker
    import sms_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [31:0] i_read_value
);

    // A result that was not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // No request is taken while a result is pending.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request accepted while a result is pending");

    // Every accepted request produces its result once it has passed the execute state.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("result missing two cycles after accept");

    // A refused word reports zero as its read value.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL || i_status == ST_EMPTY)
        |-> i_read_value == '0)
        else $error("refused word with nonzero read value");

endmodule

bind shared_memory_dual_stack sms_checker u_sms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_read_value (o_out.read_value)
);
`default_nettype wire
